FILE: rtl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM transaction sequencer.
// No dependencies; i2cee_fsm and the top level import this package.
package i2cee_pkg;

  localparam int MAX_BYTES_DEF = 64;

  localparam logic [15:0] TIMEOUT_RST  = 16'd200;
  localparam logic [6:0]  DEV_ADDR_RST = 7'd80;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'd1;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;
  localparam logic [1:0] CMD_QUEUE  = 2'd3;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_SEND      = 3'd2;
  localparam logic [2:0] ACT_STOP      = 3'd3;
  localparam logic [2:0] ACT_CLR_ADDR  = 3'd4;

  localparam logic [3:0] ERR_OK         = 4'd0;
  localparam logic [3:0] ERR_BUSY       = 4'd1;
  localparam logic [3:0] ERR_NO_START   = 4'd2;
  localparam logic [3:0] ERR_NO_ADDR    = 4'd3;
  localparam logic [3:0] ERR_NO_TXE     = 4'd4;
  localparam logic [3:0] ERR_NO_BTF     = 4'd5;
  localparam logic [3:0] ERR_NO_RESTART = 4'd6;
  localparam logic [3:0] ERR_NO_RD_ADDR = 4'd7;
  localparam logic [3:0] ERR_NO_RXNE    = 4'd8;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] mem_address;
    logic [6:0]  length;
    logic [7:0]  write_byte;
    logic        flag_busy;
    logic        flag_start_sent;
    logic        flag_addr_done;
    logic        flag_tx_empty;
    logic        flag_transfer_done;
    logic        flag_rx_full;
    logic [7:0]  rx_byte;
    logic        ms_tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_enable;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [5:0] rx_index;
    logic       done_res;
    logic [3:0] error_code;
  } result_t;

endpackage

FILE: rtl/i2cee_wqueue.sv
// Write-byte queue memory: one write port, one registered read port.
// Depends on nothing outside this file.
module i2cee_wqueue #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/i2cee_fsm.sv
// Transaction state machine, configuration registers and per-beat result logic.
// Depends on i2cee_pkg; drives the write-queue memory in i2cee_wqueue.
module i2cee_fsm
  import i2cee_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF,
  parameter int CW        = $clog2(MAX_BYTES + 1),
  parameter int AW        = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  fire,
  input  in_item_t              item,
  input  logic [7:0]            q_rdata,
  output logic                  q_we,
  output logic [AW-1:0]         q_waddr,
  output logic [AW-1:0]         q_raddr,
  output result_t               result
);

  localparam int LW = (CW > 7) ? CW : 7;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_BUSY     = 4'd1;
  localparam logic [3:0] PH_SB1      = 4'd2;
  localparam logic [3:0] PH_ADDR1    = 4'd3;
  localparam logic [3:0] PH_TXE_HI   = 4'd4;
  localparam logic [3:0] PH_TXE_LO   = 4'd5;
  localparam logic [3:0] PH_TXE_DATA = 4'd6;
  localparam logic [3:0] PH_BTF_W    = 4'd7;
  localparam logic [3:0] PH_BTF_R    = 4'd8;
  localparam logic [3:0] PH_SB2      = 4'd9;
  localparam logic [3:0] PH_ADDR2    = 4'd10;
  localparam logic [3:0] PH_RXNE     = 4'd11;

  logic [15:0]   timeout_r;
  logic [6:0]    dev_addr_r;
  logic [3:0]    phase_r, phase_nxt;
  logic          is_read_r, is_read_nxt;
  logic [15:0]   target_r, target_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] index_r, index_nxt;
  logic [15:0]   wait_r, wait_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ack_r, ack_nxt;
  logic          met;
  logic [3:0]    code;
  logic [CW-1:0] index_inc;
  logic [LW-1:0] len_w;
  logic [7:0]    dev_wr;
  logic          q_push;

  assign index_inc = index_r + CW'(1);
  assign len_w     = LW'(item.length);
  assign dev_wr    = {dev_addr_r, 1'b0};

  always_comb begin
    phase_nxt   = phase_r;
    is_read_nxt = is_read_r;
    target_nxt  = target_r;
    count_nxt   = count_r;
    index_nxt   = index_r;
    wait_nxt    = wait_r;
    fill_nxt    = fill_r;
    ack_nxt     = ack_r;
    q_push      = 1'b0;
    result      = '0;
    met         = 1'b0;
    code        = ERR_OK;

    case (phase_r)
      PH_BUSY:   begin met = ~item.flag_busy;        code = ERR_BUSY;       end
      PH_SB1:    begin met = item.flag_start_sent;   code = ERR_NO_START;   end
      PH_ADDR1:  begin met = item.flag_addr_done;    code = ERR_NO_ADDR;    end
      PH_TXE_HI, PH_TXE_LO, PH_TXE_DATA: begin
        met  = item.flag_tx_empty;
        code = ERR_NO_TXE;
      end
      PH_BTF_W, PH_BTF_R: begin
        met  = item.flag_transfer_done;
        code = ERR_NO_BTF;
      end
      PH_SB2:    begin met = item.flag_start_sent;   code = ERR_NO_RESTART; end
      PH_ADDR2:  begin met = item.flag_addr_done;    code = ERR_NO_RD_ADDR; end
      default:   begin met = item.flag_rx_full;      code = ERR_NO_RXNE;    end
    endcase

    if (phase_r == PH_IDLE) begin
      if (item.command == CMD_READ || item.command == CMD_WRITE) begin
        is_read_nxt = (item.command == CMD_READ);
        target_nxt  = item.mem_address;
        count_nxt   = (len_w > LW'(MAX_BYTES)) ? CW'(MAX_BYTES) : CW'(len_w);
        index_nxt   = '0;
        phase_nxt   = PH_BUSY;
        wait_nxt    = '0;
      end else if (item.command == CMD_QUEUE) begin
        if (fill_r < CW'(MAX_BYTES)) begin
          q_push   = 1'b1;
          fill_nxt = fill_r + CW'(1);
        end
      end
    end else if (item.command == CMD_SAMPLE) begin
      if (met) begin
        wait_nxt = '0;
        case (phase_r)
          PH_BUSY: begin
            result.action = ACT_START;
            phase_nxt     = PH_SB1;
          end
          PH_SB1: begin
            result.action  = ACT_SEND;
            result.tx_byte = dev_wr;
            phase_nxt      = PH_ADDR1;
          end
          PH_ADDR1: begin
            result.action = ACT_CLR_ADDR;
            phase_nxt     = PH_TXE_HI;
          end
          PH_TXE_HI: begin
            result.action  = ACT_SEND;
            result.tx_byte = target_r[15:8];
            phase_nxt      = PH_TXE_LO;
          end
          PH_TXE_LO: begin
            result.action  = ACT_SEND;
            result.tx_byte = target_r[7:0];
            if (is_read_r) begin
              phase_nxt = PH_BTF_R;
            end else begin
              phase_nxt = (count_r != '0) ? PH_TXE_DATA : PH_BTF_W;
            end
          end
          PH_TXE_DATA: begin
            result.action  = ACT_SEND;
            result.tx_byte = q_rdata;
            index_nxt      = index_inc;
            phase_nxt      = (index_inc >= count_r) ? PH_BTF_W : PH_TXE_DATA;
          end
          PH_BTF_W: begin
            result.action   = ACT_STOP;
            result.done_res = 1'b1;
            fill_nxt        = '0;
            phase_nxt       = PH_IDLE;
          end
          PH_BTF_R: begin
            result.action = ACT_START;
            phase_nxt     = PH_SB2;
          end
          PH_SB2: begin
            result.action  = ACT_SEND;
            result.tx_byte = dev_wr | 8'd1;
            phase_nxt      = PH_ADDR2;
          end
          PH_ADDR2: begin
            result.action = ACT_CLR_ADDR;
            ack_nxt       = 1'b1;
            if (count_r == '0) begin
              result.done_res = 1'b1;
              phase_nxt       = PH_IDLE;
            end else begin
              phase_nxt = PH_RXNE;
            end
          end
          default: begin
            if (index_inc >= count_r) begin
              ack_nxt       = 1'b0;
              result.action = ACT_STOP;
            end
            result.rx_valid = 1'b1;
            result.rx_data  = item.rx_byte;
            result.rx_index = 6'(index_r);
            index_nxt       = index_inc;
            if (index_inc >= count_r) begin
              result.done_res = 1'b1;
              phase_nxt       = PH_IDLE;
            end else begin
              phase_nxt = PH_RXNE;
            end
          end
        endcase
      end else begin
        if (item.ms_tick && wait_r != 16'hFFFF) begin
          wait_nxt = wait_r + 16'd1;
        end
        if (wait_nxt >= timeout_r) begin
          result.done_res   = 1'b1;
          result.error_code = code;
          if (!is_read_r) begin
            fill_nxt = '0;
          end
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
        end
      end
    end

    result.ack_enable = ack_nxt;
  end

  assign q_we    = fire & q_push;
  assign q_waddr = fill_r[AW-1:0];
  assign q_raddr = fire ? index_nxt[AW-1:0] : index_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
        CFG_DEV_ADDR: dev_addr_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      is_read_r <= 1'b0;
      target_r  <= '0;
      count_r   <= '0;
      index_r   <= '0;
      wait_r    <= '0;
      fill_r    <= '0;
      ack_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      is_read_r <= is_read_nxt;
      target_r  <= target_nxt;
      count_r   <= count_nxt;
      index_r   <= index_nxt;
      wait_r    <= wait_nxt;
      fill_r    <= fill_nxt;
      ack_r     <= ack_nxt;
    end
  end

endmodule

FILE: rtl/i2c_eeprom_transaction_sequencer.sv
// Top level of the I2C EEPROM transaction sequencer: input and result registers.
// Depends on i2cee_pkg, i2cee_fsm and i2cee_wqueue.
//
//  Channel  Direction  Handshake            Contents
//  in_      input      in_valid/in_ready    command or status sample, one per beat
//  out_     output     out_valid/out_ready  one result per input beat
//  cfg_     input      cfg_we               timeout and device address writes
//
// Each beat passes an input register, the combinational state-machine logic and a
// result register; one beat is taken per cycle while the result is not stalled.
// The write queue is read ahead of use from its registered port.
// A stalled result holds the input register full; in_ready drops only then.
// Reset is synchronous and active low and needs no clearing pass.
module i2c_eeprom_transaction_sequencer
  import i2cee_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [15:0]           in_mem_address,
  input  logic [6:0]            in_length,
  input  logic [7:0]            in_write_byte,
  input  logic                  in_flag_busy,
  input  logic                  in_flag_start_sent,
  input  logic                  in_flag_addr_done,
  input  logic                  in_flag_tx_empty,
  input  logic                  in_flag_transfer_done,
  input  logic                  in_flag_rx_full,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_ms_tick,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_action,
  output logic [7:0]            out_tx_byte,
  output logic                  out_ack_enable,
  output logic                  out_rx_valid,
  output logic [7:0]            out_rx_data,
  output logic [5:0]            out_rx_index,
  output logic                  out_done_res,
  output logic [3:0]            out_error_code
);

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  in_item_t      item_r;
  logic          item_vld_r;
  result_t       res_r;
  result_t       res_nxt;
  logic          out_vld_r;
  logic          fire;
  logic          q_we;
  logic [AW-1:0] q_waddr;
  logic [AW-1:0] q_raddr;
  logic [7:0]    q_rdata;

  assign fire     = item_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~item_vld_r | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{command:            in_command,
                  mem_address:        in_mem_address,
                  length:             in_length,
                  write_byte:         in_write_byte,
                  flag_busy:          in_flag_busy,
                  flag_start_sent:    in_flag_start_sent,
                  flag_addr_done:     in_flag_addr_done,
                  flag_tx_empty:      in_flag_tx_empty,
                  flag_transfer_done: in_flag_transfer_done,
                  flag_rx_full:       in_flag_rx_full,
                  rx_byte:            in_rx_byte,
                  ms_tick:            in_ms_tick};
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  i2cee_fsm #(
    .MAX_BYTES (MAX_BYTES),
    .CW        (CW),
    .AW        (AW)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item_r),
    .q_rdata   (q_rdata),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_raddr   (q_raddr),
    .result    (res_nxt)
  );

  i2cee_wqueue #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_wqueue (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (item_r.write_byte),
    .rd_addr (q_raddr),
    .rd_data (q_rdata)
  );

  assign out_valid      = out_vld_r;
  assign out_action     = res_r.action;
  assign out_tx_byte    = res_r.tx_byte;
  assign out_ack_enable = res_r.ack_enable;
  assign out_rx_valid   = res_r.rx_valid;
  assign out_rx_data    = res_r.rx_data;
  assign out_rx_index   = res_r.rx_index;
  assign out_done_res   = res_r.done_res;
  assign out_error_code = res_r.error_code;

endmodule
